FILE: rtl/loopback_packet_queue_batcher_assert.svh
// assertion macros used by the checker file
`ifndef LOOPBACK_PACKET_QUEUE_BATCHER_ASSERT_SVH
`define LOOPBACK_PACKET_QUEUE_BATCHER_ASSERT_SVH

// same-cycle implication under reset
`define LPQB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define LPQB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lpqb_pkg.sv
// shared constants, codes and helpers of the packet queue batcher
package lpqb_pkg;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned MaxPayload = 256;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned FillW      = $clog2(QueueDepth + 1);
  localparam int unsigned LenW       = $clog2(MaxPayload + 1);
  localparam int unsigned InLenW     = 12;
  localparam int unsigned IdW        = 64;
  localparam int unsigned TimeW      = 64;
  localparam int unsigned DropW      = 32;
  localparam int unsigned BatchW     = 6;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 6;
  localparam int unsigned InDataW    = 80;
  localparam int unsigned OutDataW   = 184;

  // request kinds
  localparam logic [2:0] KIND_TX     = 3'd0;
  localparam logic [2:0] KIND_INJECT = 3'd1;
  localparam logic [2:0] KIND_TICK   = 3'd2;
  localparam logic [2:0] KIND_FLUSH  = 3'd3;
  localparam logic [2:0] KIND_PEEK   = 3'd4;

  // result kinds
  localparam logic [1:0] RES_SENT   = 2'd0;
  localparam logic [1:0] RES_STATUS = 2'd1;
  localparam logic [1:0] RES_PEEK   = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LOOPBACK = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PERF     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BATCH    = 2'd2;

  // output tdata bit positions
  localparam int unsigned OffId     = 0;
  localparam int unsigned OffLen    = OffId + IdW;
  localparam int unsigned OffTime   = OffLen + LenW;
  localparam int unsigned OffRx     = OffTime + TimeW;
  localparam int unsigned OffTx     = OffRx + FillW;
  localparam int unsigned OffDrop   = OffTx + FillW;
  localparam int unsigned OffFailed = OffDrop + DropW;

  typedef struct packed {
    logic [DropW-1:0] dropped_total;
    logic [FillW-1:0] tx_depth;
    logic [FillW-1:0] rx_depth;
    logic [TimeW-1:0] packet_time;
    logic [LenW-1:0]  packet_len;
    logic [IdW-1:0]   pkt_id;
  } result_body_t;

  function automatic logic [LenW-1:0] clamp_len(input logic [InLenW-1:0] len);
    logic [LenW-1:0] res;
    if (len > InLenW'(MaxPayload)) res = LenW'(MaxPayload);
    else                           res = len[LenW-1:0];
    return res;
  endfunction

endpackage

FILE: rtl/lpqb_ram.sv
// single-port-write, single-port-read ram with registered read data
module lpqb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/loopback_packet_queue_batcher.sv
// loopback packet queue batcher: transmit batching ring plus receive ring
// one request at a time: a new request is taken only when the previous step,
//   including every flushed entry (one ram read, one emit) and any output stall, is done
// reset: async active low; rings empty, next id 1, drop count 0, loopback on,
//   performance mode off, batch limit 32; ram contents are not cleared
module loopback_packet_queue_batcher
  import lpqb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // packet_length[11:0], timestamp[75:12], zero pad
  input  logic [2:0]          s_axis_tuser,   // kind[2:0]
  // result channel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // pkt_id, packet_len, packet_time, rx_depth,
                                              // tx_depth, dropped_total, failed, zero pad
  output logic [1:0]          m_axis_tuser,   // result_kind[1:0]
  output logic                m_axis_tlast,   // last
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FLUSH_RD, ST_FLUSH_WR, ST_TX_PUSH, ST_PERF_SEND,
    ST_RX_INJECT, ST_PEEK_RD, ST_PEEK_WR, ST_STATUS
  } state_e;

  localparam int unsigned SumW   = FillW + 1;
  localparam int unsigned TxMemW = LenW + IdW;
  localparam int unsigned RxMemW = LenW + TimeW + IdW;

  state_e state_q;

  // configuration
  logic              loopback_q, perf_q;
  logic [BatchW-1:0] batch_q;

  // latched request
  logic [LenW-1:0]  len_q;
  logic [TimeW-1:0] time_q;
  logic             flush_pre_q;  // flush of a full ring before the enqueue

  // ring pointers and counters
  logic [AddrW-1:0] rx_front_q, tx_front_q;
  logic [FillW-1:0] rx_fill_q, tx_fill_q;
  logic [IdW-1:0]   next_id_q, last_rx_id_q;
  logic [DropW-1:0] drop_q;

  // end-of-step values, stamped on every result of the step
  logic [FillW-1:0] end_rx_q, end_tx_q;

  // output register
  logic                m_valid_q, m_last_q;
  logic [1:0]          m_user_q;
  logic [OutDataW-1:0] m_data_q;

  logic                accept, out_free;
  logic [LenW-1:0]     in_len;

  // end-of-step precompute
  logic [SumW-1:0]  f_ext, f_after_pre, f_after_push, sends, pushes, end_tx_d;
  logic [SumW-1:0]  rx_sum, drops, end_rx_d;
  logic [DropW:0]   drop_sum;
  logic [DropW-1:0] drop_end_d;
  logic             tx_full, batch_hit;

  // ram ports
  logic              tx_we, tx_re, rx_we, rx_re;
  logic [AddrW-1:0]  tx_waddr, rx_waddr, rx_raddr;
  logic [TxMemW-1:0] tx_wdata, tx_rdata;
  logic [RxMemW-1:0] rx_wdata, rx_rdata;

  // emit path
  logic         emit, emit_last, emit_failed;
  logic [1:0]   emit_kind;
  result_body_t emit_body;
  logic [IdW-1:0]   emit_id;
  logic [LenW-1:0]  emit_len;
  logic [TimeW-1:0] emit_time;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign in_len        = clamp_len(s_axis_tdata[InLenW-1:0]);

  // how many entries the step sends and pushes, and where the rings end up
  always_comb begin
    f_ext        = SumW'(tx_fill_q);
    tx_full      = (tx_fill_q == FillW'(QueueDepth));
    f_after_pre  = tx_full ? '0 : f_ext;
    f_after_push = f_after_pre + SumW'(1);
    batch_hit    = (f_after_push >= SumW'(batch_q));
    sends        = '0;
    pushes       = '0;
    end_tx_d     = f_ext;
    unique case (s_axis_tuser)
      KIND_TX: begin
        if (perf_q) begin
          sends = SumW'(1);
        end else begin
          sends    = (tx_full ? f_ext : '0) + (batch_hit ? f_after_push : '0);
          end_tx_d = batch_hit ? '0 : f_after_push;
        end
        pushes = loopback_q ? sends : '0;
      end
      KIND_INJECT: pushes = SumW'(1);
      KIND_TICK: begin
        if (!perf_q) begin
          pushes   = loopback_q ? f_ext : '0;
          end_tx_d = '0;
        end
      end
      KIND_FLUSH: begin
        pushes   = loopback_q ? f_ext : '0;
        end_tx_d = '0;
      end
      default: ;
    endcase
    rx_sum     = SumW'(rx_fill_q) + pushes;
    drops      = (rx_sum > SumW'(QueueDepth)) ? rx_sum - SumW'(QueueDepth) : '0;
    end_rx_d   = (rx_sum > SumW'(QueueDepth)) ? SumW'(QueueDepth) : rx_sum;
    drop_sum   = {1'b0, drop_q} + (DropW+1)'(drops);
    drop_end_d = drop_sum[DropW] ? '1 : drop_sum[DropW-1:0];
  end

  // ram control and result selection
  always_comb begin
    tx_we       = (state_q == ST_TX_PUSH);
    tx_waddr    = tx_front_q + tx_fill_q[AddrW-1:0];
    tx_wdata    = {len_q, next_id_q};
    tx_re       = (state_q == ST_FLUSH_RD) && (tx_fill_q != '0);
    rx_re       = (state_q == ST_PEEK_RD) && (rx_fill_q != '0);
    rx_raddr    = rx_front_q + rx_fill_q[AddrW-1:0] - AddrW'(1);
    emit        = 1'b0;
    emit_last   = 1'b0;
    emit_failed = 1'b0;
    emit_kind   = RES_STATUS;
    emit_id     = last_rx_id_q;
    emit_len    = '0;
    emit_time   = '0;
    rx_we       = 1'b0;
    rx_wdata    = {len_q, time_q, next_id_q};
    unique case (state_q)
      ST_FLUSH_WR: begin
        emit      = out_free;
        emit_kind = RES_SENT;
        emit_id   = tx_rdata[IdW-1:0];
        emit_len  = tx_rdata[TxMemW-1:IdW];
        rx_we     = out_free && loopback_q;
        rx_wdata  = {tx_rdata[TxMemW-1:IdW], time_q, next_id_q};
      end
      ST_PERF_SEND: begin
        emit      = out_free;
        emit_kind = RES_SENT;
        emit_id   = '0;
        emit_len  = len_q;
        rx_we     = out_free && loopback_q;
      end
      ST_RX_INJECT: rx_we = 1'b1;
      ST_PEEK_RD: begin
        if (rx_fill_q == '0) begin
          emit        = out_free;
          emit_last   = 1'b1;
          emit_kind   = RES_PEEK;
          emit_id     = '0;
          emit_failed = 1'b1;
        end
      end
      ST_PEEK_WR: begin
        emit      = out_free;
        emit_last = 1'b1;
        emit_kind = RES_PEEK;
        emit_id   = rx_rdata[IdW-1:0];
        emit_time = rx_rdata[IdW+TimeW-1:IdW];
        emit_len  = rx_rdata[RxMemW-1:IdW+TimeW];
      end
      ST_STATUS: begin
        emit      = out_free;
        emit_last = 1'b1;
      end
      default: ;
    endcase
    // a full ring overwrites its oldest slot, which is front itself
    rx_waddr  = rx_front_q + rx_fill_q[AddrW-1:0];
    emit_body = '{dropped_total: drop_q, tx_depth: end_tx_q, rx_depth: end_rx_q,
                  packet_time: emit_time, packet_len: emit_len, pkt_id: emit_id};
  end

  lpqb_ram #(.WIDTH(TxMemW), .DEPTH(QueueDepth)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_front_q),
    .rdata_o (tx_rdata)
  );

  lpqb_ram #(.WIDTH(RxMemW), .DEPTH(QueueDepth)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loopback_q <= 1'b1;
      perf_q     <= 1'b0;
      batch_q    <= BatchW'(QueueDepth);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOOPBACK: loopback_q <= cfg_data_i[0];
        CFG_PERF:     perf_q     <= cfg_data_i[0];
        CFG_BATCH:    batch_q    <= cfg_data_i[BatchW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      flush_pre_q  <= 1'b0;
      len_q        <= '0;
      time_q       <= '0;
      rx_front_q   <= '0;
      rx_fill_q    <= '0;
      tx_front_q   <= '0;
      tx_fill_q    <= '0;
      next_id_q    <= IdW'(1);
      last_rx_id_q <= '0;
      drop_q       <= '0;
      end_rx_q     <= '0;
      end_tx_q     <= '0;
    end else begin
      // receive push, shared by flush, performance send and inject
      if (rx_we) begin
        if (rx_fill_q == FillW'(QueueDepth)) rx_front_q <= rx_front_q + AddrW'(1);
        else                                 rx_fill_q  <= rx_fill_q + FillW'(1);
        last_rx_id_q <= next_id_q;
        next_id_q    <= next_id_q + IdW'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            // hold the request fields for the whole step
            len_q    <= in_len;
            time_q   <= s_axis_tdata[InLenW +: TimeW];
            end_rx_q <= end_rx_d[FillW-1:0];
            end_tx_q <= end_tx_d[FillW-1:0];
            drop_q   <= drop_end_d;
            unique case (s_axis_tuser)
              KIND_TX: begin
                flush_pre_q <= 1'b1;
                if (perf_q)       state_q <= ST_PERF_SEND;
                else if (tx_full) state_q <= ST_FLUSH_RD;
                else              state_q <= ST_TX_PUSH;
              end
              KIND_INJECT: state_q <= ST_RX_INJECT;
              KIND_TICK: begin
                flush_pre_q <= 1'b0;
                state_q     <= perf_q ? ST_STATUS : ST_FLUSH_RD;
              end
              KIND_FLUSH: begin
                flush_pre_q <= 1'b0;
                state_q     <= ST_FLUSH_RD;
              end
              KIND_PEEK: state_q <= ST_PEEK_RD;
              default:   state_q <= ST_STATUS;
            endcase
          end
        end
        ST_FLUSH_RD: begin
          if (tx_fill_q == '0) state_q <= flush_pre_q ? ST_TX_PUSH : ST_STATUS;
          else                 state_q <= ST_FLUSH_WR;
        end
        ST_FLUSH_WR: begin
          if (out_free) begin
            tx_front_q <= tx_front_q + AddrW'(1);
            tx_fill_q  <= tx_fill_q - FillW'(1);
            state_q    <= ST_FLUSH_RD;
          end
        end
        ST_TX_PUSH: begin
          tx_fill_q   <= tx_fill_q + FillW'(1);
          next_id_q   <= next_id_q + IdW'(1);
          flush_pre_q <= 1'b0;
          if (SumW'(tx_fill_q) + SumW'(1) >= SumW'(batch_q)) state_q <= ST_FLUSH_RD;
          else                                                state_q <= ST_STATUS;
        end
        ST_PERF_SEND: begin
          if (out_free) state_q <= ST_STATUS;
        end
        ST_RX_INJECT: state_q <= ST_STATUS;
        ST_PEEK_RD: begin
          if (rx_fill_q != '0) state_q <= ST_PEEK_WR;
          else if (out_free)   state_q <= ST_IDLE;
        end
        ST_PEEK_WR, ST_STATUS: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_user_q <= emit_kind;
      m_last_q <= emit_last;
      m_data_q <= OutDataW'({emit_failed, emit_body});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: rtl/lpqb_checker.sv
// port-level checker for the packet queue batcher, bound to the top level
`include "loopback_packet_queue_batcher_assert.svh"

module lpqb_checker
  import lpqb_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  // a stalled result stays offered
  `LPQB_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
                    "result dropped while stalled")

  // status and peek answers close their step
  `LPQB_ASSERT_NOW(a_close, clk_i, rst_ni,
                   m_axis_tvalid && (m_axis_tuser == RES_STATUS || m_axis_tuser == RES_PEEK),
                   m_axis_tlast, "closing result without last")

  // sent packets never close a step
  `LPQB_ASSERT_NOW(a_sent_open, clk_i, rst_ni,
                   m_axis_tvalid && m_axis_tuser == RES_SENT, !m_axis_tlast,
                   "sent packet marked last")

  // a failed peek carries no packet
  `LPQB_ASSERT_NOW(a_failed, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[OffFailed],
                   m_axis_tuser == RES_PEEK && m_axis_tdata[OffLen+LenW-1:OffId] == '0,
                   "failed flag on a non-empty or non-peek result")

  // ring depths stay within capacity
  `LPQB_ASSERT_NOW(a_depth, clk_i, rst_ni, m_axis_tvalid,
                   m_axis_tdata[OffRx+FillW-1:OffRx] <= FillW'(QueueDepth) &&
                   m_axis_tdata[OffTx+FillW-1:OffTx] <= FillW'(QueueDepth),
                   "ring depth beyond capacity")

endmodule

bind loopback_packet_queue_batcher lpqb_checker u_lpqb_checker (.*);

FILE: tb/loopback_packet_queue_batcher_tb.sv
// testbench of the loopback packet queue batcher: directed and random requests, checked results
`timescale 1ns / 100ps

module loopback_packet_queue_batcher_tb;
  import lpqb_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 24;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IdW-1:0]   id;
    logic [LenW-1:0]  len;
    logic [TimeW-1:0] ptime;
    logic [FillW-1:0] rx;
    logic [FillW-1:0] tx;
    logic [DropW-1:0] drop;
    logic             failed;
    logic             last;
  } packet_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // packet_length, timestamp, zero pad
  logic [2:0]          s_axis_tuser = '0;   // kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // id, len, time, rx, tx, drop, failed, pad
  logic [1:0]          m_axis_tuser;        // result_kind
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  loopback_packet_queue_batcher dut (.*);

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state, mirrors the block
  logic [IdW-1:0]   rx_ids [QueueDepth];
  logic [TimeW-1:0] rx_times [QueueDepth];
  logic [LenW-1:0]  rx_lens [QueueDepth];
  logic [IdW-1:0]   tx_ids [QueueDepth];
  logic [LenW-1:0]  tx_lens [QueueDepth];
  int unsigned      rx_head, rx_used, tx_head, tx_used;
  logic [IdW-1:0]   id_counter;
  logic [DropW-1:0] drops;
  logic [IdW-1:0]   newest_rx_id;
  logic             loopback_on;
  logic             perf_on;
  logic [BatchW-1:0] batch_threshold;

  packet_result_t step_results[$];
  packet_result_t expected_results[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // one line per mismatch, and count it
  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic void emit(input logic [1:0] kind, input logic [IdW-1:0] id,
                               input logic [LenW-1:0] len, input logic [TimeW-1:0] tm,
                               input logic failed);
    packet_result_t r;
    r = '0;
    r.kind = kind;
    r.id = id;
    r.len = len;
    r.ptime = tm;
    r.failed = failed;
    step_results.push_back(r);
  endfunction

  function automatic void rx_enqueue(input logic [LenW-1:0] len, input logic [TimeW-1:0] tm);
    int unsigned slot;
    if (rx_used >= QueueDepth) begin
      // oldest entry falls out
      rx_head = (rx_head + 1) % QueueDepth;
      if (drops != '1) drops++;
      rx_used = QueueDepth - 1;
    end
    slot = (rx_head + rx_used) % QueueDepth;
    rx_ids[slot] = id_counter;
    rx_times[slot] = tm;
    rx_lens[slot] = len;
    newest_rx_id = id_counter;
    id_counter++;
    rx_used++;
  endfunction

  function automatic void transmit(input logic [IdW-1:0] id, input logic [LenW-1:0] len,
                                   input logic [TimeW-1:0] tm);
    emit(RES_SENT, id, len, '0, 1'b0);
    if (loopback_on) rx_enqueue(len, tm);
  endfunction

  function automatic void drain_tx_ring(input logic [TimeW-1:0] tm);
    while (tx_used != 0) begin
      transmit(tx_ids[tx_head], tx_lens[tx_head], tm);
      tx_head = (tx_head + 1) % QueueDepth;
      tx_used--;
    end
  endfunction

  // expected results of one accepted request
  function automatic void predict_request(input logic [2:0] kind,
                                          input logic [InLenW-1:0] raw_len,
                                          input logic [TimeW-1:0] tm);
    logic [LenW-1:0] len;
    int unsigned slot;
    len = (raw_len > InLenW'(MaxPayload)) ? LenW'(MaxPayload) : raw_len[LenW-1:0];
    step_results.delete();
    case (kind)
      KIND_TX: begin
        if (perf_on) begin
          transmit('0, len, tm);
        end else begin
          if (tx_used >= QueueDepth) drain_tx_ring(tm);
          slot = (tx_head + tx_used) % QueueDepth;
          tx_ids[slot] = id_counter;
          tx_lens[slot] = len;
          id_counter++;
          tx_used++;
          if (tx_used >= batch_threshold) drain_tx_ring(tm);
        end
      end
      KIND_INJECT: begin
        rx_enqueue(len, tm);
      end
      KIND_TICK: begin
        if (!perf_on) drain_tx_ring(tm);
      end
      KIND_FLUSH: begin
        drain_tx_ring(tm);
      end
      default: ;
    endcase
    if (kind == KIND_PEEK) begin
      if (rx_used == 0) begin
        emit(RES_PEEK, '0, '0, '0, 1'b1);
      end else begin
        slot = (rx_head + rx_used - 1) % QueueDepth;
        emit(RES_PEEK, rx_ids[slot], rx_lens[slot], rx_times[slot], 1'b0);
      end
    end else begin
      emit(RES_STATUS, newest_rx_id, '0, '0, 1'b0);
    end
    // depths and drop count are end-of-request values in every result
    foreach (step_results[k]) begin
      step_results[k].rx = FillW'(rx_used);
      step_results[k].tx = FillW'(tx_used);
      step_results[k].drop = drops;
      step_results[k].last = (k == step_results.size() - 1);
      expected_results.push_back(step_results[k]);
    end
  endfunction

  // result side: random stall at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result check at the rising edge
  always @(posedge clk_i) begin
    packet_result_t want;
    packet_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got.kind = m_axis_tuser;
      got.id = m_axis_tdata[OffId +: IdW];
      got.len = m_axis_tdata[OffLen +: LenW];
      got.ptime = m_axis_tdata[OffTime +: TimeW];
      got.rx = m_axis_tdata[OffRx +: FillW];
      got.tx = m_axis_tdata[OffTx +: FillW];
      got.drop = m_axis_tdata[OffDrop +: DropW];
      got.failed = m_axis_tdata[OffFailed];
      got.last = m_axis_tlast;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d id %0h", got.kind, got.id));
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
          report($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
        if (got.id !== want.id)
          report($sformatf("id %0h, want %0h", got.id, want.id));
        if (got.len !== want.len)
          report($sformatf("packet_len %0d, want %0d", got.len, want.len));
        if (got.ptime !== want.ptime)
          report($sformatf("packet_time %0h, want %0h", got.ptime, want.ptime));
        if (got.rx !== want.rx)
          report($sformatf("rx_depth %0d, want %0d", got.rx, want.rx));
        if (got.tx !== want.tx)
          report($sformatf("tx_depth %0d, want %0d", got.tx, want.tx));
        if (got.drop !== want.drop)
          report($sformatf("dropped_total %0d, want %0d", got.drop, want.drop));
        if (got.failed !== want.failed)
          report($sformatf("failed %0b, want %0b", got.failed, want.failed));
        if (got.last !== want.last)
          report($sformatf("last %0b, want %0b", got.last, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("loopback_packet_queue_batcher_tb failed");
      $finish;
    end
  end

  // one request; valid stays high into the next request unless a gap is drawn
  task automatic send_request(input logic [2:0] kind, input logic [InLenW-1:0] len,
                              input logic [TimeW-1:0] tm);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = kind;
    s_axis_tdata = {{(InDataW - InLenW - TimeW){1'b0}}, tm, len};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(kind, len, tm);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // hold off until every expected result has come and the block has settled
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    wait_drained();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_LOOPBACK: loopback_on = val[0];
      CFG_PERF:     perf_on = val[0];
      CFG_BATCH:    batch_threshold = val[BatchW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input logic lb, input logic perf, input logic [BatchW-1:0] batch);
    write_register(CFG_LOOPBACK, CfgDataW'(lb));
    write_register(CFG_PERF, CfgDataW'(perf));
    write_register(CFG_BATCH, CfgDataW'(batch));
  endtask

  function automatic logic [TimeW-1:0] random_time();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [InLenW-1:0] random_len();
    case ($urandom_range(5))
      0: return '0;
      1: return InLenW'(MaxPayload);
      2: return InLenW'(MaxPayload + 1);
      3: return '1;
      4: return InLenW'($urandom_range(MaxPayload));
      default: return InLenW'($urandom());
    endcase
  endfunction

  function automatic logic [2:0] random_kind();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return KIND_TX;
    if (pick < 64) return KIND_INJECT;
    if (pick < 74) return KIND_TICK;
    if (pick < 82) return KIND_FLUSH;
    if (pick < 95) return KIND_PEEK;
    return 3'($urandom_range(7, 5));
  endfunction

  // reset-default mode: empty peeks, empty flushes, length clamp, unknown kinds
  task automatic test_directed();
    send_request(KIND_PEEK, '0, '0);
    send_request(KIND_TICK, '0, '0);
    send_request(KIND_FLUSH, '1, '1);
    send_request(3'd5, '0, '0);
    send_request(3'd6, '1, '1);
    send_request(3'd7, 12'h5a5, 64'ha5a5_a5a5_a5a5_a5a5);
    send_request(KIND_TX, '0, '0);
    send_request(KIND_TX, InLenW'(MaxPayload), '1);
    send_request(KIND_TX, InLenW'(MaxPayload + 1), 64'h0123_4567_89ab_cdef);
    send_request(KIND_TX, '1, 64'hfedc_ba98_7654_3210);
    send_request(KIND_TICK, 12'h0ff, 64'h8000_0000_0000_0001);
    send_request(KIND_PEEK, '0, '0);
    send_request(KIND_INJECT, '1, '1);
    send_request(KIND_INJECT, 12'h0aa, 64'h5555_5555_5555_5555);
    send_request(KIND_PEEK, '0, '0);
    send_request(KIND_TX, 12'd17, 64'd3);
    send_request(KIND_FLUSH, '0, 64'd4);
    send_request(KIND_PEEK, '0, '0);
  endtask

  // performance mode: immediate sends with id 0, ticks ignored
  task automatic test_performance_mode();
    set_mode(1'b1, 1'b1, BatchW'(4));
    send_request(KIND_TX, 12'd42, 64'd100);
    send_request(KIND_TX, '1, '1);
    send_request(KIND_TICK, '0, '0);
    send_request(KIND_PEEK, '0, '0);
  endtask

  // random traffic across register settings and idle patterns
  task automatic test_random_phases();
    logic [BatchW-1:0] batches [6] = '{BatchW'(1), '0, BatchW'(5), BatchW'(QueueDepth),
                                       '1, BatchW'(40)};
    logic loopbacks [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    logic perfs [6] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    for (int p = 0; p < 6; p++) begin
      // idle pattern changes every two phases
      send_idle_pct = (p < 2) ? 31 : (p < 4) ? 71 : 0;
      recv_idle_pct = (p < 2) ? 71 : (p < 4) ? 31 : 0;
      set_mode(loopbacks[p], perfs[p], batches[p]);
      for (int n = 0; n < 33; n++) begin
        send_request(random_kind(), random_len(), random_time());
        // sender backs off until the result stream has caught up
        if (n == 16) wait_drained();
      end
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    requests_sent = 0;
    results_seen = 0;
    send_idle_pct = 31;
    recv_idle_pct = 71;
    rx_head = 0;
    rx_used = 0;
    tx_head = 0;
    tx_used = 0;
    id_counter = 64'd1;
    drops = '0;
    newest_rx_id = '0;
    loopback_on = 1'b1;
    perf_on = 1'b0;
    batch_threshold = BatchW'(QueueDepth);
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_performance_mode();
    test_random_phases();

    wait_drained();
    $display("covered %0d requests and %0d results over six register settings,",
             requests_sent, results_seen);
    $display("with stalls on either side and none, including empty peeks and ring overflow");
    if (errors == 0) begin
      $display("loopback_packet_queue_batcher_tb passed");
    end else begin
      $display("loopback_packet_queue_batcher_tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lpqb_pkg.sv
rtl/lpqb_ram.sv
rtl/loopback_packet_queue_batcher.sv
rtl/lpqb_checker.sv
tb/loopback_packet_queue_batcher_tb.sv
